// File: hdl/tgpn_pkg.sv
// Shared types, codes and helpers for the touch gesture page navigator.
`default_nettype none

package tgpn_pkg;

	localparam int unsigned CoordW = 12;
	localparam int unsigned PageW  = 16;
	localparam int unsigned TickW  = 16;
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 16;

	// event kinds
	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_PRESS   = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	// result actions
	localparam logic [2:0] ACT_NONE = 3'd0;
	localparam logic [2:0] ACT_NEXT = 3'd1;
	localparam logic [2:0] ACT_PREV = 3'd2;
	localparam logic [2:0] ACT_EXIT = 3'd3;
	localparam logic [2:0] ACT_SHOW = 3'd4;
	localparam logic [2:0] ACT_HIDE = 3'd5;

	// register indexes
	localparam logic [CfgIdxW-1:0] CFG_SWIPE_MIN        = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_TAP_MAX          = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_SCREEN_WIDTH     = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_PAGE_COUNT       = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_OVERLAY_TIMEOUT  = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_BACK_ZONE_WIDTH  = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_BACK_ZONE_HEIGHT = 3'd6;

	// reset values
	localparam logic [CoordW-1:0] RST_SWIPE_MIN        = 12'd50;
	localparam logic [CoordW-1:0] RST_TAP_MAX          = 12'd20;
	localparam int unsigned       RstScreenWidth       = 540;
	localparam logic [CoordW-1:0] RST_SCREEN_WIDTH     = CoordW'(RstScreenWidth);
	localparam logic [CoordW-1:0] RST_THIRD            = CoordW'(RstScreenWidth / 3);
	localparam logic [CoordW-1:0] RST_TWO_THIRDS       = CoordW'((RstScreenWidth * 2) / 3);
	localparam logic [PageW-1:0]  RST_PAGE_COUNT       = 16'd0;
	localparam logic [TickW-1:0]  RST_OVERLAY_TIMEOUT  = 16'd3000;
	localparam logic [CoordW-1:0] RST_BACK_ZONE_WIDTH  = 12'd100;
	localparam logic [CoordW-1:0] RST_BACK_ZONE_HEIGHT = 12'd50;

	typedef struct packed {
		logic [1:0]        operation;
		logic [CoordW-1:0] touch_x;
		logic [CoordW-1:0] touch_y;
	} in_word_t;

	typedef struct packed {
		logic [2:0]       action;
		logic [PageW-1:0] page_number;
		logic             redraw;
		logic             overlay_visible;
		logic             exit_requested;
	} out_word_t;

	// thresholds seen by the gesture classifier
	typedef struct packed {
		logic [CoordW-1:0] swipe_min;
		logic [CoordW-1:0] tap_max;
		logic [CoordW-1:0] third;
		logic [CoordW-1:0] two_thirds;
		logic [CoordW-1:0] back_zone_width;
		logic [CoordW-1:0] back_zone_height;
	} gest_cfg_t;

	typedef enum logic [1:0] {
		GEST_NONE = 2'd0,
		GEST_NEXT = 2'd1,
		GEST_PREV = 2'd2,
		GEST_EXIT = 2'd3
	} gest_t;

	// floor(v/3) for v < 8192: v*2731 >> 13 is exact over that range
	function automatic logic [CoordW-1:0] div3(input logic [CoordW:0] v);
		logic [25:0] p;
		p = 26'(v) * 26'd2731;
		return p[24:13];
	endfunction

endpackage

`default_nettype wire

// File: hdl/tgpn_gesture.sv
// Release gesture classifier: back corner, swipe or tap in an outer third.
`default_nettype none

module tgpn_gesture (
	input  wire logic [11:0]        start_x,
	input  wire logic [11:0]        start_y,
	input  wire logic [11:0]        end_x,
	input  wire logic [11:0]        end_y,
	input  wire tgpn_pkg::gest_cfg_t cfg,
	output tgpn_pkg::gest_t          gesture
);

	logic [12:0] dx, dy, ndx, ndy;
	logic [11:0] adx, ady;

	always_comb begin
		dx  = {1'b0, end_x} - {1'b0, start_x};
		dy  = {1'b0, end_y} - {1'b0, start_y};
		ndx = -dx;
		ndy = -dy;
		adx = dx[12] ? ndx[11:0] : dx[11:0];
		ady = dy[12] ? ndy[11:0] : dy[11:0];

		gesture = tgpn_pkg::GEST_NONE;
		if (start_x < cfg.back_zone_width && start_y < cfg.back_zone_height) begin
			gesture = tgpn_pkg::GEST_EXIT;
		end else if (adx > cfg.swipe_min && adx > ady) begin
			// finger moving left turns forward
			gesture = dx[12] ? tgpn_pkg::GEST_NEXT : tgpn_pkg::GEST_PREV;
		end else if (adx < cfg.tap_max && ady < cfg.tap_max) begin
			if (start_x < cfg.third) begin
				gesture = tgpn_pkg::GEST_PREV;
			end else if (start_x > cfg.two_thirds) begin
				gesture = tgpn_pkg::GEST_NEXT;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/touch_gesture_page_navigator.sv
// Throughput: one event word per cycle while results are taken; input register,
// one compare stage, result register, with the state updated as each word leaves
// the input register, where its result is computed and then registered.
// Reset: asynchronous, active low; clears both stages, sets the registers to their
// defaults, page 0, overlay shown, tick count and exit flag cleared.
`default_nettype none

module touch_gesture_page_navigator (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              touch_valid,
	output logic                                   touch_ready,
	input  wire tgpn_pkg::in_word_t                touch,
	output logic                                   result_valid,
	input  wire logic                              result_ready,
	output tgpn_pkg::out_word_t                    result,
	input  wire logic                              cfg_write,
	input  wire logic [tgpn_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire logic [tgpn_pkg::CfgDataW-1:0]     cfg_data
);

	// configuration
	logic [11:0] swipe_min_q, tap_max_q, third_q, two_thirds_q;
	logic [11:0] back_zone_width_q, back_zone_height_q;
	logic [15:0] page_count_q, overlay_timeout_q;

	// navigator state
	logic [11:0] start_x_q, start_y_q;
	logic        touch_active_q;
	logic [15:0] page_index_q;
	logic        overlay_shown_q;
	logic [15:0] overlay_ticks_q;
	logic        exit_flag_q;

	// pipeline
	logic                valid_s1;
	tgpn_pkg::in_word_t  word_s1;
	logic                result_valid_q;
	tgpn_pkg::out_word_t result_q;
	logic                advance;

	tgpn_pkg::gest_cfg_t gcfg;
	tgpn_pkg::gest_t     gesture;

	logic [11:0] start_x_d, start_y_d;
	logic        touch_active_d;
	logic [15:0] page_index_d;
	logic        overlay_shown_d;
	logic [15:0] overlay_ticks_d, ticks_inc;
	logic        exit_flag_d;
	logic [2:0]  act;
	logic        can_next;
	tgpn_pkg::out_word_t res_d;

	assign advance      = valid_s1 && (!result_valid_q || result_ready);
	assign touch_ready  = !valid_s1 || advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign gcfg.swipe_min        = swipe_min_q;
	assign gcfg.tap_max          = tap_max_q;
	assign gcfg.third            = third_q;
	assign gcfg.two_thirds       = two_thirds_q;
	assign gcfg.back_zone_width  = back_zone_width_q;
	assign gcfg.back_zone_height = back_zone_height_q;

	tgpn_gesture u_gesture (
		.start_x (start_x_q),
		.start_y (start_y_q),
		.end_x   (word_s1.touch_x),
		.end_y   (word_s1.touch_y),
		.cfg     (gcfg),
		.gesture (gesture)
	);

	always_comb begin
		start_x_d       = start_x_q;
		start_y_d       = start_y_q;
		touch_active_d  = touch_active_q;
		page_index_d    = page_index_q;
		overlay_shown_d = overlay_shown_q;
		overlay_ticks_d = overlay_ticks_q;
		exit_flag_d     = exit_flag_q;
		act             = tgpn_pkg::ACT_NONE;
		ticks_inc       = (overlay_ticks_q != '1) ? overlay_ticks_q + 16'd1 : overlay_ticks_q;
		can_next        = ({1'b0, page_index_q} + 17'd1) < {1'b0, page_count_q};

		unique case (word_s1.operation)
			tgpn_pkg::OP_TICK: begin
				if (overlay_shown_q) begin
					overlay_ticks_d = ticks_inc;
					if (ticks_inc > overlay_timeout_q) begin
						overlay_shown_d = 1'b0;
						act             = tgpn_pkg::ACT_HIDE;
					end
				end
			end
			tgpn_pkg::OP_PRESS: begin
				start_x_d      = word_s1.touch_x;
				start_y_d      = word_s1.touch_y;
				touch_active_d = 1'b1;
				if (!overlay_shown_q) begin
					overlay_shown_d = 1'b1;
					overlay_ticks_d = '0;
					act             = tgpn_pkg::ACT_SHOW;
				end
			end
			tgpn_pkg::OP_RELEASE: begin
				if (touch_active_q) begin
					touch_active_d = 1'b0;
					unique case (gesture)
						tgpn_pkg::GEST_EXIT: begin
							exit_flag_d = 1'b1;
							act         = tgpn_pkg::ACT_EXIT;
						end
						tgpn_pkg::GEST_NEXT: begin
							if (can_next) begin
								page_index_d = page_index_q + 16'd1;
								act          = tgpn_pkg::ACT_NEXT;
							end
						end
						tgpn_pkg::GEST_PREV: begin
							if (page_index_q != '0) begin
								page_index_d = page_index_q - 16'd1;
								act          = tgpn_pkg::ACT_PREV;
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase

		res_d.action          = act;
		res_d.page_number     = page_index_d;
		res_d.redraw          = (act != tgpn_pkg::ACT_NONE) && (act != tgpn_pkg::ACT_EXIT);
		res_d.overlay_visible = overlay_shown_d;
		res_d.exit_requested  = exit_flag_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swipe_min_q        <= tgpn_pkg::RST_SWIPE_MIN;
			tap_max_q          <= tgpn_pkg::RST_TAP_MAX;
			third_q            <= tgpn_pkg::RST_THIRD;
			two_thirds_q       <= tgpn_pkg::RST_TWO_THIRDS;
			page_count_q       <= tgpn_pkg::RST_PAGE_COUNT;
			overlay_timeout_q  <= tgpn_pkg::RST_OVERLAY_TIMEOUT;
			back_zone_width_q  <= tgpn_pkg::RST_BACK_ZONE_WIDTH;
			back_zone_height_q <= tgpn_pkg::RST_BACK_ZONE_HEIGHT;
		end else if (cfg_write) begin
			unique case (cfg_index)
				tgpn_pkg::CFG_SWIPE_MIN:        swipe_min_q        <= cfg_data[11:0];
				tgpn_pkg::CFG_TAP_MAX:          tap_max_q          <= cfg_data[11:0];
				tgpn_pkg::CFG_SCREEN_WIDTH: begin
					// thirds kept ready so the release path only compares
					third_q      <= tgpn_pkg::div3({1'b0, cfg_data[11:0]});
					two_thirds_q <= tgpn_pkg::div3({cfg_data[11:0], 1'b0});
				end
				tgpn_pkg::CFG_PAGE_COUNT:       page_count_q       <= cfg_data;
				tgpn_pkg::CFG_OVERLAY_TIMEOUT:  overlay_timeout_q  <= cfg_data;
				tgpn_pkg::CFG_BACK_ZONE_WIDTH:  back_zone_width_q  <= cfg_data[11:0];
				tgpn_pkg::CFG_BACK_ZONE_HEIGHT: back_zone_height_q <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q       <= '0;
			start_y_q       <= '0;
			touch_active_q  <= 1'b0;
			page_index_q    <= '0;
			overlay_shown_q <= 1'b1;
			overlay_ticks_q <= '0;
			exit_flag_q     <= 1'b0;
		end else begin
			if (advance) begin
				start_x_q       <= start_x_d;
				start_y_q       <= start_y_d;
				touch_active_q  <= touch_active_d;
				overlay_shown_q <= overlay_shown_d;
				overlay_ticks_q <= overlay_ticks_d;
				exit_flag_q     <= exit_flag_d;
			end
			// a page count write clamps the index
			if (cfg_write && cfg_index == tgpn_pkg::CFG_PAGE_COUNT) begin
				if (cfg_data == '0) begin
					page_index_q <= '0;
				end else if (page_index_q >= cfg_data) begin
					page_index_q <= cfg_data - 16'd1;
				end
			end else if (advance) begin
				page_index_q <= page_index_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (touch_ready) begin
				valid_s1 <= touch_valid;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (touch_ready && touch_valid) begin
			word_s1 <= touch;
		end
		if (advance) begin
			result_q <= res_d;
		end
	end

`ifndef SYNTHESIS
	a_page_zero_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		page_count_q == '0 |-> page_index_q == '0)
		else $error("page index not zero with no pages");

	a_page_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		page_count_q != '0 |-> page_index_q < page_count_q)
		else $error("page index beyond page count");

	a_exit_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		exit_flag_q |=> exit_flag_q)
		else $error("exit flag cleared");

	a_hide_word_hidden: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && result_q.action == tgpn_pkg::ACT_HIDE
		|-> !result_q.overlay_visible && result_q.redraw)
		else $error("hide word reports overlay visible");
`endif

endmodule

`default_nettype wire
